/* sv/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer: screen
// geometry, character codes, command codes and controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int ScreenColumns = 80;
  localparam int ScreenRows    = 25;
  localparam int CellCount     = ScreenColumns * ScreenRows;

  localparam int ColW   = $clog2(ScreenColumns + 1);
  localparam int RowW   = $clog2(ScreenRows + 1);
  localparam int AddrW  = $clog2(CellCount);
  localparam int SweepW = $clog2(CellCount + ScreenColumns);
  localparam int CellW  = 16;
  localparam int CharW  = 8;
  localparam int CoordW = 8;
  localparam int CmdW   = 2;

  localparam logic [CharW-1:0] TextColorReset = 8'h17;
  localparam logic [CharW-1:0] BlankChar      = 8'h20;
  localparam logic [CharW-1:0] CodeNewline    = 8'h0A;
  localparam logic [CharW-1:0] CodeReturn     = 8'h0D;
  localparam logic [CharW-1:0] FirstPrintable = 8'd32;

  typedef enum logic [CmdW-1:0] {
    CMD_PUT    = 2'd0,
    CMD_SETPOS = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } command_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_FILL_ZERO,
    OP_FILL_BLANK,
    OP_WRAP,
    OP_SCROLL_RD,
    OP_SCROLL_WR,
    OP_SCROLL_BLANK,
    OP_PUT
  } dp_op_e;

  typedef struct packed {
    logic need_scroll;
    logic store_end;
    logic blank_end;
  } dp_status_t;

endpackage

/* sv/tcw_datapath.sv */
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen store, cursor, text color and sweep address; performs the
// operation that the controller selects each cycle.
// ----------------------------------------------------------------------------
module tcw_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tcw_pkg::dp_op_e             op_i,
  input  logic [tcw_pkg::CmdW-1:0]    command_i,
  input  logic [tcw_pkg::CharW-1:0]   char_code_i,
  input  logic [tcw_pkg::CoordW-1:0]  column_i,
  input  logic [tcw_pkg::CoordW-1:0]  row_i,
  input  logic                        cfg_valid_i,
  input  logic [tcw_pkg::CharW-1:0]   cfg_data_i,
  output tcw_pkg::dp_status_t         status_o,
  output logic [tcw_pkg::CellW-1:0]   cell_data_o,
  output logic [tcw_pkg::ColW-1:0]    cursor_column_o,
  output logic [tcw_pkg::RowW-1:0]    cursor_row_o
);

  logic [tcw_pkg::CellW-1:0]  screen_q [tcw_pkg::CellCount];
  logic [tcw_pkg::CellW-1:0]  rdata_q;
  logic [tcw_pkg::ColW-1:0]   col_q, col_d;
  logic [tcw_pkg::RowW-1:0]   row_q, row_d;
  logic [tcw_pkg::CharW-1:0]  color_q;
  logic [tcw_pkg::CharW-1:0]  char_q;
  logic                       rd_hit_q, rd_hit_d;
  logic [tcw_pkg::SweepW-1:0] addr_q, addr_d;

  logic                       we, re;
  logic [tcw_pkg::AddrW-1:0]  waddr, raddr;
  logic [tcw_pkg::CellW-1:0]  wdata;

  logic                       wrap_pend;
  logic [tcw_pkg::RowW:0]     row_w;
  logic                       need_scroll;
  logic                       in_range;
  logic [tcw_pkg::AddrW-1:0]  cur_index, in_index;
  logic [tcw_pkg::SweepW-1:0] sweep_dst;
  logic [tcw_pkg::CellW-1:0]  blank_cell;

  assign wrap_pend   = (col_q == tcw_pkg::ColW'(tcw_pkg::ScreenColumns));
  assign row_w       = {1'b0, row_q} + (tcw_pkg::RowW + 1)'(wrap_pend);
  assign need_scroll = (row_w >= (tcw_pkg::RowW + 1)'(tcw_pkg::ScreenRows));
  assign in_range    = (column_i < tcw_pkg::CoordW'(tcw_pkg::ScreenColumns)) &&
                       (row_i < tcw_pkg::CoordW'(tcw_pkg::ScreenRows));
  assign cur_index   = tcw_pkg::AddrW'(row_q) * tcw_pkg::AddrW'(tcw_pkg::ScreenColumns) +
                       tcw_pkg::AddrW'(col_q);
  assign in_index    = tcw_pkg::AddrW'(row_i[tcw_pkg::RowW-1:0]) *
                       tcw_pkg::AddrW'(tcw_pkg::ScreenColumns) +
                       tcw_pkg::AddrW'(column_i[tcw_pkg::ColW-1:0]);
  assign sweep_dst   = addr_q - tcw_pkg::SweepW'(tcw_pkg::ScreenColumns);
  assign blank_cell  = {color_q, tcw_pkg::BlankChar};

  always_comb begin
    we       = 1'b0;
    re       = 1'b0;
    waddr    = addr_q[tcw_pkg::AddrW-1:0];
    raddr    = addr_q[tcw_pkg::AddrW-1:0];
    wdata    = blank_cell;
    col_d    = col_q;
    row_d    = row_q;
    rd_hit_d = rd_hit_q;
    addr_d   = addr_q;
    unique case (op_i)
      tcw_pkg::OP_LATCH: begin
        rd_hit_d = (command_i == tcw_pkg::CMD_READ) && in_range;
        re       = (command_i == tcw_pkg::CMD_READ) && in_range;
        raddr    = in_index;
        if (command_i == tcw_pkg::CMD_CLEAR) begin
          addr_d = '0;
        end
        if (command_i == tcw_pkg::CMD_SETPOS) begin
          col_d = (column_i > tcw_pkg::CoordW'(tcw_pkg::ScreenColumns - 1)) ?
                  tcw_pkg::ColW'(tcw_pkg::ScreenColumns - 1) :
                  column_i[tcw_pkg::ColW-1:0];
          row_d = (row_i > tcw_pkg::CoordW'(tcw_pkg::ScreenRows - 1)) ?
                  tcw_pkg::RowW'(tcw_pkg::ScreenRows - 1) :
                  row_i[tcw_pkg::RowW-1:0];
        end
      end
      tcw_pkg::OP_FILL_ZERO: begin
        we     = 1'b1;
        wdata  = '0;
        addr_d = addr_q + 1'b1;
      end
      tcw_pkg::OP_FILL_BLANK: begin
        we     = 1'b1;
        addr_d = addr_q + 1'b1;
      end
      tcw_pkg::OP_WRAP: begin
        if (wrap_pend) begin
          col_d = '0;
        end
        if (need_scroll) begin
          row_d  = tcw_pkg::RowW'(tcw_pkg::ScreenRows - 1);
          addr_d = tcw_pkg::SweepW'(2 * tcw_pkg::ScreenColumns);
        end else begin
          row_d = row_w[tcw_pkg::RowW-1:0];
        end
      end
      tcw_pkg::OP_SCROLL_RD: begin
        re = 1'b1;
      end
      tcw_pkg::OP_SCROLL_WR: begin
        we     = 1'b1;
        waddr  = sweep_dst[tcw_pkg::AddrW-1:0];
        wdata  = rdata_q;
        addr_d = addr_q + 1'b1;
      end
      tcw_pkg::OP_SCROLL_BLANK: begin
        we     = 1'b1;
        waddr  = sweep_dst[tcw_pkg::AddrW-1:0];
        addr_d = addr_q + 1'b1;
      end
      tcw_pkg::OP_PUT: begin
        if (char_q == tcw_pkg::CodeNewline) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else if (char_q == tcw_pkg::CodeReturn) begin
          col_d = '0;
        end else if (char_q >= tcw_pkg::FirstPrintable) begin
          we    = 1'b1;
          waddr = cur_index;
          wdata = {color_q, char_q};
          col_d = col_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // screen store
  always_ff @(posedge clk_i) begin
    if (we) begin
      screen_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= screen_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == tcw_pkg::OP_LATCH) begin
      char_q <= char_code_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q    <= '0;
      row_q    <= '0;
      color_q  <= tcw_pkg::TextColorReset;
      rd_hit_q <= 1'b0;
      addr_q   <= '0;
    end else begin
      col_q    <= col_d;
      row_q    <= row_d;
      rd_hit_q <= rd_hit_d;
      addr_q   <= addr_d;
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  assign status_o.need_scroll = need_scroll;
  assign status_o.store_end   = (addr_q == tcw_pkg::SweepW'(tcw_pkg::CellCount - 1));
  assign status_o.blank_end   = (addr_q == tcw_pkg::SweepW'(tcw_pkg::CellCount +
                                                         tcw_pkg::ScreenColumns - 1));

  assign cell_data_o     = rd_hit_q ? rdata_q : '0;
  assign cursor_column_o = col_q;
  assign cursor_row_o    = row_q;

endmodule

/* sv/tcw_controller.sv */
// ----------------------------------------------------------------------------
// tcw_controller
// Command sequencer: reset clear, command accept, wrap and scroll handling,
// clear sweep and result strobe.
// ----------------------------------------------------------------------------
module tcw_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [tcw_pkg::CmdW-1:0] command_i,
  input  tcw_pkg::dp_status_t      status_i,
  output tcw_pkg::dp_op_e          op_o,
  output logic                     busy_o,
  output logic                     result_valid_o
);

  typedef enum logic [8:0] {
    S_INIT      = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_WRAP      = 9'b000000100,
    S_SCR_RD    = 9'b000001000,
    S_SCR_WR    = 9'b000010000,
    S_SCR_BLANK = 9'b000100000,
    S_PUT       = 9'b001000000,
    S_CLEAR     = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o         = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign result_valid_o = (state_q == S_DONE);
  assign accept         = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    op_o    = tcw_pkg::OP_NONE;
    unique case (state_q)
      S_INIT: begin
        op_o = tcw_pkg::OP_FILL_ZERO;
        if (status_i.store_end) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE, S_DONE: begin
        state_d = S_IDLE;
        if (accept) begin
          op_o = tcw_pkg::OP_LATCH;
          unique case (tcw_pkg::command_e'(command_i))
            tcw_pkg::CMD_PUT:    state_d = S_WRAP;
            tcw_pkg::CMD_SETPOS: state_d = S_DONE;
            tcw_pkg::CMD_CLEAR:  state_d = S_CLEAR;
            tcw_pkg::CMD_READ:   state_d = S_DONE;
            default:             state_d = S_DONE;
          endcase
        end
      end
      S_WRAP: begin
        op_o    = tcw_pkg::OP_WRAP;
        state_d = status_i.need_scroll ? S_SCR_RD : S_PUT;
      end
      S_SCR_RD: begin
        op_o    = tcw_pkg::OP_SCROLL_RD;
        state_d = S_SCR_WR;
      end
      S_SCR_WR: begin
        op_o    = tcw_pkg::OP_SCROLL_WR;
        state_d = status_i.store_end ? S_SCR_BLANK : S_SCR_RD;
      end
      S_SCR_BLANK: begin
        op_o = tcw_pkg::OP_SCROLL_BLANK;
        if (status_i.blank_end) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        op_o    = tcw_pkg::OP_PUT;
        state_d = S_DONE;
      end
      S_CLEAR: begin
        op_o = tcw_pkg::OP_FILL_BLANK;
        if (status_i.store_end) begin
          state_d = S_DONE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* sv/text_console_writer.sv */
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over an 80 x 25 screen of 16-bit cells
// (attribute byte high, character byte low).
// ----------------------------------------------------------------------------
// After reset the block holds busy high while it zeroes the screen store,
// one cell per cycle. A command is taken when start is high and busy is
// low; its result appears for one cycle with result_valid_o and must be
// captured then. Set position and read cell give their result in the cycle
// after the command is taken, so one can be issued every cycle. Put character
// passes through a wrap step and a put step; when a scroll is pending, each
// cell of rows 2 to 24 is first moved up one row by a read and a write, and
// then the last row is blanked. Clear screen writes one cell per cycle. A new
// command may be issued in the cycle its predecessor shows its result. The
// text color register is always ready; the user must write it only while no
// command is in progress, and the block itself does not enforce this.
module text_console_writer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [tcw_pkg::CmdW-1:0]     command_i,
  input  logic [tcw_pkg::CharW-1:0]    char_code_i,
  input  logic [tcw_pkg::CoordW-1:0]   column_i,
  input  logic [tcw_pkg::CoordW-1:0]   row_i,
  output logic                         result_valid_o,
  output logic [tcw_pkg::CellW-1:0]    cell_data_o,
  output logic [tcw_pkg::ColW-1:0]     cursor_column_o,
  output logic [tcw_pkg::RowW-1:0]     cursor_row_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tcw_pkg::CharW-1:0]    cfg_data_i
);

  tcw_pkg::dp_op_e     op;
  tcw_pkg::dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tcw_controller u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .command_i      (command_i),
    .status_i       (status),
    .op_o           (op),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  tcw_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .op_i            (op),
    .command_i       (command_i),
    .char_code_i     (char_code_i),
    .column_i        (column_i),
    .row_i           (row_i),
    .cfg_valid_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .status_o        (status),
    .cell_data_o     (cell_data_o),
    .cursor_column_o (cursor_column_o),
    .cursor_row_o    (cursor_row_o)
  );

`ifndef SYNTHESIS
  a_read_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == tcw_pkg::CMD_READ)) |=> result_valid_o)
    else $error("read cell result not given in the next cycle");

  a_setpos_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (command_i == tcw_pkg::CMD_SETPOS)) |=>
    (result_valid_o &&
     (cursor_column_o < tcw_pkg::ColW'(tcw_pkg::ScreenColumns)) &&
     (cursor_row_o < tcw_pkg::RowW'(tcw_pkg::ScreenRows))))
    else $error("set position left cursor outside the screen");

  a_cursor_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cursor_column_o <= tcw_pkg::ColW'(tcw_pkg::ScreenColumns)) &&
    (cursor_row_o <= tcw_pkg::RowW'(tcw_pkg::ScreenRows)))
    else $error("cursor beyond pending wrap or scroll position");

  a_idle_cursor_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!busy && !start) |=> ($stable(cursor_column_o) && $stable(cursor_row_o)))
    else $error("cursor moved without a command");
`endif

endmodule
